// File: sv/ostb_pkg.sv
// Package of the one-shot timer bank: field widths, command and result codes,
// and the word that travels down the chain of timer cells. No dependencies.
package ostb_pkg;

   localparam int MODE_W  = 2;
   localparam int INDEX_W = 4;
   localparam int TIME_W  = 32;
   localparam int TAG_W   = 8;
   localparam int CODE_W  = 2;

   typedef enum logic [MODE_W-1:0] {
      MODE_TICK     = 2'd0,
      MODE_REGISTER = 2'd1,
      MODE_CLEAR    = 2'd2,
      MODE_READ     = 2'd3
   } mode_type;

   typedef enum logic [CODE_W-1:0] {
      CODE_ARMED   = 2'd0,
      CODE_BUSY    = 2'd1,
      CODE_CLEARED = 2'd2,
      CODE_NONE    = 2'd3
   } code_type;

   // One command word on its way through the cells, with its partial result.
   typedef struct packed {
      logic                valid;
      mode_type            mode;
      logic [INDEX_W-1:0]  timer_index;
      logic [TIME_W-1:0]   duration_ms;
      logic [TAG_W-1:0]    tag_in;
      logic [TIME_W-1:0]   now;
      code_type            result_code;
      logic [TAG_W-1:0]    tag_out;
      logic                expired_out;
   } chain_word_type;

endpackage

// File: sv/ostb_if.sv
// Channel interfaces of the one-shot timer bank: command words in, result words out.
// Depends on ostb_pkg for the field widths.
interface ostb_req_if;
   logic                          valid;
   logic                          ready;
   logic [ostb_pkg::MODE_W-1:0]   mode;
   logic [ostb_pkg::INDEX_W-1:0]  timer_index;
   logic [ostb_pkg::TIME_W-1:0]   duration_ms;
   logic [ostb_pkg::TAG_W-1:0]    tag_in;

   modport source (output valid, mode, timer_index, duration_ms, tag_in, input ready);
   modport sink   (input valid, mode, timer_index, duration_ms, tag_in, output ready);
endinterface

interface ostb_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ostb_pkg::CODE_W-1:0]   result_code;
   logic [ostb_pkg::TAG_W-1:0]    tag_out;
   logic                          expired_out;

   modport source (output valid, result_code, tag_out, expired_out, input ready);
   modport sink   (input valid, result_code, tag_out, expired_out, output ready);
endinterface

// File: sv/ostb_cell.sv
// One timer slot of the bank: holds the slot's stores and passes the command word on.
// Depends on ostb_pkg.
module ostb_cell #(
   parameter int CELL_INDEX = 0
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  ostb_pkg::chain_word_type word_in,
   output ostb_pkg::chain_word_type word_out
);
   import ostb_pkg::*;

   logic [TIME_W-1:0] start_ff, start_in;
   logic [TIME_W-1:0] length_ff, length_in;
   logic              armed_ff, armed_in;
   logic              expired_ff, expired_in;
   logic [TAG_W-1:0]  tag_ff, tag_in;
   chain_word_type    word_ff, word_in_next;

   logic              match;
   logic [TIME_W-1:0] elapsed;

   assign match   = word_in.valid && (int'(word_in.timer_index) == CELL_INDEX);
   assign elapsed = word_in.now - start_ff;

   always_comb begin
      start_in     = start_ff;
      length_in    = length_ff;
      armed_in     = armed_ff;
      expired_in   = expired_ff;
      tag_in       = tag_ff;
      word_in_next = word_in;
      if (word_in.valid) begin
         case (word_in.mode)
            MODE_TICK: begin
               if (armed_ff && (elapsed >= length_ff)) begin
                  expired_in = 1'b1;
               end
            end
            MODE_REGISTER: begin
               if (match && (length_ff == '0)) begin
                  length_in  = word_in.duration_ms;
                  start_in   = word_in.now;
                  expired_in = 1'b0;
                  armed_in   = 1'b1;
                  tag_in     = word_in.tag_in;
                  word_in_next.result_code = CODE_ARMED;
               end
            end
            MODE_CLEAR: begin
               if (match) begin
                  length_in  = '0;
                  start_in   = '0;
                  expired_in = 1'b0;
                  armed_in   = 1'b0;
                  tag_in     = '0;
               end
            end
            default: begin
            end
         endcase
         // The addressed slot reports its stores as they stand after the command.
         if (match) begin
            word_in_next.tag_out     = tag_in;
            word_in_next.expired_out = expired_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff      <= '0;
         length_ff     <= '0;
         armed_ff      <= 1'b0;
         expired_ff    <= 1'b0;
         tag_ff        <= '0;
         word_ff.valid <= 1'b0;
      end else if (advance) begin
         start_ff   <= start_in;
         length_ff  <= length_in;
         armed_ff   <= armed_in;
         expired_ff <= expired_in;
         tag_ff     <= tag_in;
         word_ff    <= word_in_next;
      end
   end

   assign word_out = word_ff;

endmodule

// File: sv/one_shot_timer_bank.sv
// Top level of the one-shot timer bank: time counter, entry stage and the chain of cells.
// Depends on ostb_pkg, ostb_if (ostb_req_if, ostb_rsp_if) and ostb_cell.
//
//   channel  | direction | word contents
//   ---------+-----------+------------------------------------------------
//   req_chan | in        | mode, timer_index, duration_ms, tag_in
//   rsp_chan | out       | result_code, tag_out, expired_out
//
// Each command word walks down a row of TIMER_COUNT cells, one cell per cycle while the
// row advances. The accepting edge loads it into the first cell, and it then passes
// through the register of each cell in order; the last cell's word is the result word.
// The row is fully pipelined: a new word can be accepted in every cycle, one per clock
// sustained, as long as no waiting result holds the row.
// Reset (synchronous, active high) clears the time counter and all slot stores.
// While a result word waits at rsp_chan without being taken, the whole row holds
// and req_chan.ready is low.
module one_shot_timer_bank #(
   parameter int TIMER_COUNT = 16
) (
   input  logic       clock,
   input  logic       reset,
   ostb_req_if.sink   req_chan,
   ostb_rsp_if.source rsp_chan
);
   import ostb_pkg::*;

   // Millisecond counter; it counts accepted tick words.
   logic [TIME_W-1:0] now_ff, now_in;

   logic              advance;
   logic              req_take;
   chain_word_type    chain [TIMER_COUNT+1];
   chain_word_type    entry_word;

   // The row moves as a whole whenever the last cell's word can leave.
   assign advance      = !chain[TIMER_COUNT].valid || rsp_chan.ready;
   assign req_chan.ready = advance;
   assign req_take     = req_chan.valid && advance;

   always_comb begin
      now_in = now_ff;
      if (req_take && (mode_type'(req_chan.mode) == MODE_TICK)) begin
         now_in = now_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff <= '0;
      end else begin
         now_ff <= now_in;
      end
   end

   // The entry word carries the time the command sees and a default result.
   // A slot beyond the bank never matches, so its tag and flag report zero.
   always_comb begin
      entry_word.valid       = req_chan.valid;
      entry_word.mode        = mode_type'(req_chan.mode);
      entry_word.timer_index = req_chan.timer_index;
      entry_word.duration_ms = req_chan.duration_ms;
      entry_word.tag_in      = req_chan.tag_in;
      entry_word.now         = now_in;
      entry_word.tag_out     = '0;
      entry_word.expired_out = 1'b0;
      case (mode_type'(req_chan.mode))
         MODE_REGISTER: begin
            entry_word.result_code = CODE_BUSY;
         end
         MODE_CLEAR: begin
            entry_word.result_code = CODE_CLEARED;
         end
         default: begin
            entry_word.result_code = CODE_NONE;
         end
      endcase
   end

   assign chain[0] = entry_word;

   for (genvar g = 0; g < TIMER_COUNT; g++) begin : g_cell
      ostb_cell #(
         .CELL_INDEX (g)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .word_in  (chain[g]),
         .word_out (chain[g+1])
      );
   end

   assign rsp_chan.valid       = chain[TIMER_COUNT].valid;
   assign rsp_chan.result_code = chain[TIMER_COUNT].result_code;
   assign rsp_chan.tag_out     = chain[TIMER_COUNT].tag_out;
   assign rsp_chan.expired_out = chain[TIMER_COUNT].expired_out;

   // The counter moves by one on an accepted tick and holds otherwise.
   a_now_tick : assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready && (req_chan.mode == MODE_TICK)
      |=> now_ff == $past(now_ff) + 1'b1)
      else $error("time counter did not advance on a tick");

   a_now_hold : assert property (@(posedge clock) disable iff (reset)
      !(req_chan.valid && req_chan.ready && (req_chan.mode == MODE_TICK))
      |=> now_ff == $past(now_ff))
      else $error("time counter moved without a tick");

   // A waiting result stalls the whole row, including the entry.
   a_stall : assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.ready |-> !req_chan.ready)
      else $error("input accepted while the row is stalled");

   // Only a register command can report armed.
   a_armed_mode : assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && (rsp_chan.result_code == CODE_ARMED)
      |-> chain[TIMER_COUNT].mode == MODE_REGISTER)
      else $error("armed reported for a command other than register");

   // A slot beyond the bank reports an empty tag and a clear flag.
   a_out_of_bank : assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && (int'(chain[TIMER_COUNT].timer_index) >= TIMER_COUNT)
      |-> (rsp_chan.tag_out == '0) && !rsp_chan.expired_out)
      else $error("slot beyond the bank reported stored data");

endmodule

// File: verif/slot_table_tracker_pkg.sv
`timescale 1ns / 1ps
// Expected-word tracker for the one-shot timer bank testbench: its own copy of the slot
// table, the queue of result words still to arrive, and the comparison. Needs ostb_pkg.
package slot_table_tracker_pkg;
   import ostb_pkg::*;

   localparam int SLOT_COUNT = 16;

   typedef struct packed {
      code_type           result_code;
      logic [TAG_W-1:0]   tag_out;
      logic               expired_out;
   } reply_word_type;

   class slot_table_tracker;
      logic [TIME_W-1:0] now_ms;
      logic [TIME_W-1:0] start_ms  [SLOT_COUNT];
      logic [TIME_W-1:0] length_ms [SLOT_COUNT];
      logic              armed     [SLOT_COUNT];
      logic              expired   [SLOT_COUNT];
      logic [TAG_W-1:0]  tag_store [SLOT_COUNT];
      reply_word_type    pending_replies [$];
      int unsigned       mismatches;

      function new();
         now_ms = '0;
         for (int s = 0; s < SLOT_COUNT; s++) begin
            start_ms[s]  = '0;
            length_ms[s] = '0;
            armed[s]     = 1'b0;
            expired[s]   = 1'b0;
            tag_store[s] = '0;
         end
         mismatches = 0;
      endfunction

      // Applies one accepted command word to the table and queues the word it must return.
      function void note_command(mode_type mode, logic [INDEX_W-1:0] index,
                                 logic [TIME_W-1:0] duration, logic [TAG_W-1:0] tag);
         reply_word_type    reply;
         logic [TIME_W-1:0] elapsed;
         int                slot;
         bit                in_bank;
         slot    = int'(index);
         in_bank = slot < SLOT_COUNT;
         reply.result_code = CODE_NONE;
         case (mode)
            MODE_TICK: begin
               now_ms = now_ms + 1;
               for (int s = 0; s < SLOT_COUNT; s++) begin
                  elapsed = now_ms - start_ms[s];
                  if (armed[s] && elapsed >= length_ms[s]) expired[s] = 1'b1;
               end
            end
            MODE_REGISTER: begin
               reply.result_code = CODE_BUSY;
               if (in_bank && length_ms[slot] == '0) begin
                  length_ms[slot] = duration;
                  start_ms[slot]  = now_ms;
                  expired[slot]   = 1'b0;
                  armed[slot]     = 1'b1;
                  tag_store[slot] = tag;
                  reply.result_code = CODE_ARMED;
               end
            end
            MODE_CLEAR: begin
               reply.result_code = CODE_CLEARED;
               if (in_bank) begin
                  length_ms[slot] = '0;
                  start_ms[slot]  = '0;
                  expired[slot]   = 1'b0;
                  armed[slot]     = 1'b0;
                  tag_store[slot] = '0;
               end
            end
            default: ;
         endcase
         reply.tag_out     = in_bank ? tag_store[slot] : '0;
         reply.expired_out = in_bank ? expired[slot] : 1'b0;
         pending_replies.push_back(reply);
      endfunction

      function void check_reply(logic [CODE_W-1:0] code, logic [TAG_W-1:0] tag,
                                logic expired_bit);
         reply_word_type want;
         if (pending_replies.size() == 0) begin
            $display("%0t: unexpected result word: code %0d tag 0x%02h expired %0d",
                     $time, code, tag, expired_bit);
            mismatches++;
            return;
         end
         want = pending_replies.pop_front();
         if (code !== want.result_code) begin
            $display("%0t: result_code mismatch: expected %0d, actual %0d",
                     $time, want.result_code, code);
            mismatches++;
         end
         if (tag !== want.tag_out) begin
            $display("%0t: tag_out mismatch: expected 0x%02h, actual 0x%02h",
                     $time, want.tag_out, tag);
            mismatches++;
         end
         if (expired_bit !== want.expired_out) begin
            $display("%0t: expired_out mismatch: expected %0d, actual %0d",
                     $time, want.expired_out, expired_bit);
            mismatches++;
         end
      endfunction

      function int unsigned outstanding();
         return pending_replies.size();
      endfunction
   endclass

endpackage

// File: verif/testbench.sv
`timescale 1ns / 1ps
// Top of the one-shot timer bank testbench: clock, reset, command driver, result
// receiver and watchdog. Needs ostb_pkg, ostb_if, the block itself and slot_table_tracker_pkg.
module testbench;
   import ostb_pkg::*;
   import slot_table_tracker_pkg::*;

   // A correct run never goes this long without moving a word on either channel. The
   // longest quiet stretch is the receiver's long hold-off once the row is full.
   localparam int QUIET_LIMIT   = 3000;
   localparam int RANDOM_ITEMS  = 1200;
   localparam int HOLD_CYCLES   = 250;
   localparam int HOLD_AFTER    = 400;
   localparam int DRAIN_CYCLES  = 2 * SLOT_COUNT + 8;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ostb_req_if req_chan ();
   ostb_rsp_if rsp_chan ();

   one_shot_timer_bank #(
      .TIMER_COUNT (SLOT_COUNT)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   slot_table_tracker slot_table = new();

   int unsigned replies_taken = 0;
   int unsigned quiet_cycles  = 0;

   // Period of 12 ns, low half first.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // The driver changes inputs at the falling edge only; everything is sampled at the
   // rising edge, so the two never meet in one time step.
   task automatic send_command(mode_type mode, logic [INDEX_W-1:0] index,
                               logic [TIME_W-1:0] duration, logic [TAG_W-1:0] tag);
      @(negedge clock);
      req_chan.valid       = 1'b1;
      req_chan.mode        = mode;
      req_chan.timer_index = index;
      req_chan.duration_ms = duration;
      req_chan.tag_in      = tag;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      // The word went in at this edge, so the table copy moves on with it.
      slot_table.note_command(mode, index, duration, tag);
   endtask

   // Lowers valid for a number of cycles between bursts.
   task automatic sender_gap(int unsigned cycles);
      if (cycles == 0) return;
      @(negedge clock);
      req_chan.valid = 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   // Hand-picked words: the reset contents, zero duration on a slot that stays free, a
   // busy slot, expiry after the exact count of ticks, the widest duration and the
   // extreme tags and slots. The counter cannot wrap within a run of this size, so the
   // modulo elapsed time is only exercised through the ordinary small differences.
   task automatic run_directed();
      send_command(MODE_READ,     4'd0,  32'd0,          8'h00);
      send_command(MODE_READ,     4'd15, 32'd0,          8'h00);
      send_command(MODE_REGISTER, 4'd0,  32'd0,          8'h5A);
      send_command(MODE_TICK,     4'd0,  32'hFFFF_FFFF,  8'hFF);
      // Slot 0 still counts as free, so this one arms it again and clears its flag.
      send_command(MODE_REGISTER, 4'd0,  32'd7,          8'h3C);
      send_command(MODE_READ,     4'd0,  32'd0,          8'h00);
      send_command(MODE_REGISTER, 4'd1,  32'd3,          8'hFF);
      send_command(MODE_REGISTER, 4'd1,  32'd9,          8'h11);
      send_command(MODE_TICK,     4'd1,  32'd0,          8'h00);
      send_command(MODE_TICK,     4'd1,  32'd0,          8'h00);
      send_command(MODE_TICK,     4'd1,  32'd0,          8'h00);
      send_command(MODE_REGISTER, 4'd2,  32'hFFFF_FFFF,  8'h00);
      send_command(MODE_TICK,     4'd2,  32'd0,          8'h00);
      send_command(MODE_REGISTER, 4'd2,  32'd1,          8'h42);
      send_command(MODE_REGISTER, 4'd3,  32'd1,          8'h81);
      send_command(MODE_TICK,     4'd3,  32'd0,          8'h00);
      send_command(MODE_CLEAR,    4'd1,  32'hFFFF_FFFF,  8'hFF);
      send_command(MODE_READ,     4'd1,  32'd0,          8'h00);
      send_command(MODE_CLEAR,    4'd15, 32'd0,          8'h00);
      send_command(MODE_REGISTER, 4'd15, 32'h8000_0000,  8'h7E);
      send_command(MODE_READ,     4'd15, 32'hFFFF_FFFF,  8'hFF);
      send_command(MODE_CLEAR,    4'd0,  32'd0,          8'h00);
      send_command(MODE_REGISTER, 4'd0,  32'd2,          8'hC3);
      send_command(MODE_TICK,     4'd0,  32'd0,          8'h00);
      send_command(MODE_TICK,     4'd0,  32'd0,          8'h00);
   endtask

   // Random words in bursts. Durations are mostly short so that timers really run out
   // and clears free slots often enough for new registrations to succeed; a few full
   // width durations make every bit of the field toggle.
   task automatic run_random();
      int unsigned sent;
      int unsigned burst;
      int unsigned pick;
      mode_type    mode;
      logic [TIME_W-1:0] duration;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         burst = $urandom_range(1, 40);
         for (int b = 0; b < burst && sent < RANDOM_ITEMS; b++) begin
            pick = $urandom_range(0, 99);
            if (pick < 40)      mode = MODE_TICK;
            else if (pick < 65) mode = MODE_REGISTER;
            else if (pick < 82) mode = MODE_CLEAR;
            else                mode = MODE_READ;
            pick = $urandom_range(0, 9);
            if (pick < 6)       duration = $urandom_range(0, 30);
            else if (pick < 8)  duration = '0;
            else if (pick == 8) duration = $urandom();
            else                duration = $urandom_range(1, 200);
            send_command(mode, INDEX_W'($urandom_range(0, 15)), duration,
                         TAG_W'($urandom_range(0, 255)));
            sent++;
         end
         // About a third of the bursts run straight into the next one.
         if ($urandom_range(0, 2) != 0) sender_gap($urandom_range(1, 8));
      end
   endtask

   // Receiver: ready changes at the falling edge, following segments of its own
   // pattern, plus one long hold-off once traffic is flowing so that the row fills and
   // req_chan.ready drops while the driver keeps offering words.
   initial begin
      int unsigned segment_left;
      int unsigned segment_kind;
      int unsigned hold_left;
      int unsigned phase;
      bit          hold_done;
      segment_left   = 0;
      segment_kind   = 0;
      hold_left      = 0;
      phase          = 0;
      hold_done      = 1'b0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         phase++;
         if (hold_left > 0) begin
            rsp_chan.ready = 1'b0;
            hold_left--;
         end else if (!hold_done && replies_taken >= HOLD_AFTER) begin
            hold_done      = 1'b1;
            hold_left      = HOLD_CYCLES - 1;
            rsp_chan.ready = 1'b0;
         end else begin
            if (segment_left == 0) begin
               segment_kind = $urandom_range(0, 3);
               segment_left = $urandom_range(16, 96);
            end
            segment_left--;
            case (segment_kind)
               0: rsp_chan.ready = 1'b1;
               1: rsp_chan.ready = ($urandom_range(0, 1) == 1);
               2: rsp_chan.ready = (phase % 3 != 0);
               default: rsp_chan.ready = ($urandom_range(0, 4) == 0);
            endcase
         end
      end
   end

   // Every result word taken is compared with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         slot_table.check_reply(rsp_chan.result_code, rsp_chan.tag_out, rsp_chan.expired_out);
         replies_taken <= replies_taken + 1;
      end
   end

   // Watchdog: counts cycles in which neither channel moves a word.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_chan.valid === 1'b1 && req_chan.ready === 1'b1) ||
             (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   initial begin
      // All inputs start known; reset is held high at the start, then released.
      req_chan.valid       = 1'b0;
      req_chan.mode        = '0;
      req_chan.timer_index = '0;
      req_chan.duration_ms = '0;
      req_chan.tag_in      = '0;
      reset                = 1'b1;
      repeat (11) @(negedge clock);
      reset = 1'b0;

      run_directed();
      run_random();
      @(negedge clock);
      req_chan.valid = 1'b0;

      // Drain: wait for every predicted word, then longer than the row is
      // deep so that a stray extra word would still be caught.
      while (slot_table.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (slot_table.mismatches == 0 && slot_table.outstanding() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         if (slot_table.outstanding() != 0)
            $display("%0t: %0d result words never arrived", $time, slot_table.outstanding());
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// File: one_shot_timer_bank.f
sv/ostb_pkg.sv
sv/ostb_if.sv
sv/ostb_cell.sv
sv/one_shot_timer_bank.sv
verif/slot_table_tracker_pkg.sv
verif/testbench.sv
